FILE: rtl/cpu_instruction_subset_execute_defines.svh
// Assertion macros shared by the execute block.
`ifndef CPU_INSTRUCTION_SUBSET_EXECUTE_DEFINES_SVH
`define CPU_INSTRUCTION_SUBSET_EXECUTE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define CISE_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cise check failed");

// next-cycle implication, checked out of reset
`define CISE_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cise check failed");

`endif

FILE: rtl/cise_pkg.sv
// Types, opcodes and reset values of the CPU subset execute block.
package cise_pkg;

  typedef struct packed {
    logic [7:0] opcode;
    logic [7:0] imm_low;
    logic [7:0] imm_high;
  } cise_in_t;

  typedef enum logic [1:0] {
    ST_EXEC    = 2'd0,
    ST_HALT    = 2'd1,
    ST_IGNORED = 2'd2
  } status_e;

  typedef struct packed {
    logic [15:0] next_pc;
    logic        mem_write;
    logic [15:0] mem_addr;
    logic [7:0]  mem_data;
    logic [7:0]  acc_value;
    logic [7:0]  b_value;
    logic [7:0]  c_value;
    logic [15:0] hl_value;
    logic [3:0]  flag_bits;
    status_e     status;
  } cise_out_t;

  // architectural state
  typedef struct packed {
    logic [7:0]  acc;
    logic [7:0]  b;
    logic [7:0]  c;
    logic [7:0]  h;
    logic [7:0]  l;
    logic [3:0]  flags;
    logic [15:0] pc;
    logic        halted;
  } cise_arch_t;

  localparam logic [7:0] OP_DEC_B   = 8'h05;
  localparam logic [7:0] OP_LD_B    = 8'h06;
  localparam logic [7:0] OP_DEC_C   = 8'h0D;
  localparam logic [7:0] OP_LD_C    = 8'h0E;
  localparam logic [7:0] OP_JR_NZ   = 8'h20;
  localparam logic [7:0] OP_LD_HL   = 8'h21;
  localparam logic [7:0] OP_LDD_HLA = 8'h32;
  localparam logic [7:0] OP_XOR_A   = 8'hAF;
  localparam logic [7:0] OP_JP      = 8'hC3;

  localparam int unsigned FLAG_Z_BIT = 3;
  localparam int unsigned FLAG_N_BIT = 2;
  localparam int unsigned FLAG_H_BIT = 1;
  localparam int unsigned FLAG_C_BIT = 0;

  localparam logic [3:0] FLAGS_XOR_A = 4'h8;

  localparam logic [7:0]  RST_ACC   = 8'h01;
  localparam logic [7:0]  RST_B     = 8'h00;
  localparam logic [7:0]  RST_C     = 8'h13;
  localparam logic [7:0]  RST_H     = 8'h01;
  localparam logic [7:0]  RST_L     = 8'h4D;
  localparam logic [3:0]  RST_FLAGS = 4'hB;
  localparam logic [15:0] RST_PC    = 16'h0150;

endpackage

FILE: rtl/cise_exec.sv
// Combinational decode and execute of one instruction against the current state.
module cise_exec (
  input  cise_pkg::cise_in_t   item_i,
  input  cise_pkg::cise_arch_t arch_i,
  output cise_pkg::cise_arch_t arch_o,
  output cise_pkg::cise_out_t  res_o
);
  import cise_pkg::*;

  logic [7:0]  dec_src;
  logic [7:0]  dec_res;
  logic [3:0]  dec_flags;
  logic [15:0] hl;
  logic [15:0] pc_plus2;
  logic [15:0] disp;
  logic        wr;
  status_e     status;
  cise_arch_t  nxt;

  assign hl       = {arch_i.h, arch_i.l};
  assign pc_plus2 = arch_i.pc + 16'd2;
  assign disp     = {{8{item_i.imm_low[7]}}, item_i.imm_low};

  // one decrementer shared by DEC B and DEC C
  assign dec_src = (item_i.opcode == OP_DEC_C) ? arch_i.c : arch_i.b;
  assign dec_res = dec_src - 8'd1;
  always_comb begin
    dec_flags             = '0;
    dec_flags[FLAG_Z_BIT] = (dec_res == 8'd0);
    dec_flags[FLAG_N_BIT] = 1'b1;
    dec_flags[FLAG_H_BIT] = (dec_src[3:0] == 4'd0);
    dec_flags[FLAG_C_BIT] = arch_i.flags[FLAG_C_BIT];
  end

  always_comb begin
    nxt    = arch_i;
    wr     = 1'b0;
    status = ST_EXEC;
    if (arch_i.halted) begin
      status = ST_IGNORED;
    end else begin
      unique case (item_i.opcode)
        OP_DEC_B: begin
          nxt.b     = dec_res;
          nxt.flags = dec_flags;
          nxt.pc    = arch_i.pc + 16'd1;
        end
        OP_DEC_C: begin
          nxt.c     = dec_res;
          nxt.flags = dec_flags;
          nxt.pc    = arch_i.pc + 16'd1;
        end
        OP_LD_B: begin
          nxt.b  = item_i.imm_low;
          nxt.pc = pc_plus2;
        end
        OP_LD_C: begin
          nxt.c  = item_i.imm_low;
          nxt.pc = pc_plus2;
        end
        OP_JR_NZ: begin
          nxt.pc = arch_i.flags[FLAG_Z_BIT] ? pc_plus2 : (pc_plus2 + disp);
        end
        OP_LD_HL: begin
          nxt.h  = item_i.imm_high;
          nxt.l  = item_i.imm_low;
          nxt.pc = arch_i.pc + 16'd3;
        end
        OP_LDD_HLA: begin
          wr             = 1'b1;
          {nxt.h, nxt.l} = hl - 16'd1;
          nxt.pc         = arch_i.pc + 16'd1;
        end
        OP_XOR_A: begin
          nxt.acc   = 8'd0;
          nxt.flags = FLAGS_XOR_A;
          nxt.pc    = arch_i.pc + 16'd1;
        end
        OP_JP: begin
          nxt.pc = {item_i.imm_high, item_i.imm_low};
        end
        default: begin
          nxt.halted = 1'b1;
          status     = ST_HALT;
        end
      endcase
    end
  end

  assign arch_o = nxt;

  always_comb begin
    res_o.next_pc   = nxt.pc;
    res_o.mem_write = wr;
    res_o.mem_addr  = wr ? hl : 16'd0;
    res_o.mem_data  = wr ? arch_i.acc : 8'd0;
    res_o.acc_value = nxt.acc;
    res_o.b_value   = nxt.b;
    res_o.c_value   = nxt.c;
    res_o.hl_value  = {nxt.h, nxt.l};
    res_o.flag_bits = nxt.flags;
    res_o.status    = status;
  end

endmodule

FILE: rtl/cise_state.sv
// Architectural register file: A, B, C, H, L, flags, PC and the halted mark.
module cise_state (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 upd_i,
  input  cise_pkg::cise_arch_t arch_d_i,
  input  logic                 pc_we_i,
  input  logic [15:0]          pc_wdata_i,
  output cise_pkg::cise_arch_t arch_o
);
  import cise_pkg::*;

  cise_arch_t arch_q;
  cise_arch_t arch_d;

  always_comb begin
    arch_d = arch_q;
    if (pc_we_i) begin
      arch_d.pc = pc_wdata_i;
    end else if (upd_i) begin
      arch_d = arch_d_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arch_q.acc    <= RST_ACC;
      arch_q.b      <= RST_B;
      arch_q.c      <= RST_C;
      arch_q.h      <= RST_H;
      arch_q.l      <= RST_L;
      arch_q.flags  <= RST_FLAGS;
      arch_q.pc     <= RST_PC;
      arch_q.halted <= 1'b0;
    end else begin
      arch_q <= arch_d;
    end
  end

  assign arch_o = arch_q;

endmodule

FILE: rtl/cpu_instruction_subset_execute.sv
// Top level: input register, execute stage and result register of the CPU subset.
//
//  channel  direction  handshake           payload
//  in       request    in_valid_i / stall  in_data_i  (opcode, imm_low, imm_high)
//  out      result     out_valid_o / stall out_data_o (pc, store, registers, flags)
//  cfg      write      cfg_valid_i / ready cfg_data_i (start address, loads PC)
//
// One instruction per cycle unless the result stalls: a request is registered,
// executed against the register file and written to the result register.
// Reset loads PC 0x0150 and the documented register values; no clearing pass.
// A stalled result holds the execute stage; the input register still takes one
// more request, so upstream stalls only when both stages are full.
module cpu_instruction_subset_execute (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  cise_pkg::cise_in_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output cise_pkg::cise_out_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [15:0]        cfg_data_i
);
  import cise_pkg::*;

  `include "cpu_instruction_subset_execute_defines.svh"

  logic       in_valid_q, in_valid_d;
  cise_in_t   in_q;
  logic       out_valid_q, out_valid_d;
  cise_out_t  out_q;
  logic       advance;
  logic       exec_en;
  logic       in_take;
  cise_arch_t arch;
  cise_arch_t arch_nxt;
  cise_out_t  res;

  assign advance     = !out_valid_q || !out_stall_i;
  assign exec_en     = in_valid_q && advance;
  assign in_stall_o  = in_valid_q && !advance;
  assign in_take     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = !in_valid_q;

  assign in_valid_d  = in_take || (in_valid_q && !advance);
  assign out_valid_d = exec_en || (out_valid_q && out_stall_i);

  cise_state u_state (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .upd_i      (exec_en),
    .arch_d_i   (arch_nxt),
    .pc_we_i    (cfg_valid_i && cfg_ready_o),
    .pc_wdata_i (cfg_data_i),
    .arch_o     (arch)
  );

  cise_exec u_exec (
    .item_i (in_q),
    .arch_i (arch),
    .arch_o (arch_nxt),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
    if (exec_en) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `CISE_ASSERT_NEXT(a_exec_fills_out, exec_en, out_valid_q)
  `CISE_ASSERT_NEXT(a_halt_sticky, arch.halted, arch.halted)
  `CISE_ASSERT_NOW(a_store_only_exec, out_valid_q && out_q.mem_write,
                   out_q.status == ST_EXEC)
  `CISE_ASSERT_NOW(a_no_store_zero, out_valid_q && !out_q.mem_write,
                   out_q.mem_addr == 16'd0 && out_q.mem_data == 8'd0)

endmodule
